>>> rtl/core/wpe_pkg.sv
// Package for the waypoint error body frame block: payload structs, fixed-point
// widths, CORDIC constants and the round/saturate helper.
// No dependencies.
`timescale 1ns / 1ps

package wpe_pkg;

	localparam int NumVehicles = 4;
	localparam int IdxW        = 2;
	localparam int CfgIdxW     = 3;
	localparam int CfgW        = 16;
	localparam int TimeW       = 32;
	localparam int ErrW        = 17;
	localparam int XyW         = 27;
	localparam int ZW          = 21;
	localparam int ProdW       = ErrW + XyW;
	localparam int AccW        = ProdW + 2;
	localparam int Steps       = 16;
	localparam int StepW       = 4;

	localparam logic [TimeW-1:0] WaitSeconds = TimeW'(7);
	localparam logic [14:0] HeightQ12 = 15'(1229);
	localparam logic signed [XyW-1:0] GainInvQ24 = XyW'(10188014);
	localparam logic signed [ZW-1:0] HalfPiQ16 = ZW'(102944);
	localparam logic signed [ZW-1:0] PiQ16 = ZW'(205887);

	// register list: ref_x0..ref_x3 then ref_y0..ref_y3; the top index bit picks y
	localparam logic signed [CfgW-1:0] RefXReset [NumVehicles] =
		'{16'sd1638, 16'sd1638, -16'sd1638, -16'sd1638};
	localparam logic signed [CfgW-1:0] RefYReset [NumVehicles] =
		'{16'sd1638, -16'sd1638, -16'sd1638, 16'sd1638};

	typedef struct packed {
		logic [IdxW-1:0]    vehicle_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] heading;
		logic [TimeW-1:0]   now_seconds;
		logic               frame_end;
	} in_item_t;

	typedef struct packed {
		logic [IdxW-1:0]    out_index;
		logic signed [15:0] body_err_x;
		logic signed [15:0] body_err_y;
		logic [14:0]        height_ref;
		logic signed [15:0] yaw_err;
		logic               out_last;
	} out_item_t;

	function automatic logic signed [ZW-1:0] atan_q16(input logic [StepW-1:0] step);
		logic signed [ZW-1:0] v;
		case (step)
			4'd0:    v = ZW'(51472);
			4'd1:    v = ZW'(30386);
			4'd2:    v = ZW'(16055);
			4'd3:    v = ZW'(8150);
			4'd4:    v = ZW'(4091);
			4'd5:    v = ZW'(2047);
			4'd6:    v = ZW'(1024);
			4'd7:    v = ZW'(512);
			4'd8:    v = ZW'(256);
			4'd9:    v = ZW'(128);
			4'd10:   v = ZW'(64);
			4'd11:   v = ZW'(32);
			4'd12:   v = ZW'(16);
			4'd13:   v = ZW'(8);
			4'd14:   v = ZW'(4);
			4'd15:   v = ZW'(2);
			default: v = '0;
		endcase
		return v;
	endfunction

	// round half up at bit 24, floor shift, clamp to 16 bits
	function automatic logic signed [15:0] sat_round(input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] r;
		r = (acc + (AccW'(1) <<< 23)) >>> 24;
		if (r > AccW'(32767))
			return 16'sh7fff;
		else if (r < AccW'(-32768))
			return 16'sh8000;
		return r[15:0];
	endfunction

endpackage

>>> rtl/core/wpe_cordic.sv
// Iterative CORDIC in rotation mode: one shift-add step per cycle, 16 steps.
// Gives cos/sin of the heading scaled by 2^24. Depends on wpe_pkg.
`timescale 1ns / 1ps

module wpe_cordic (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [15:0]               heading,
	output logic                             done,
	output logic signed [wpe_pkg::XyW-1:0]   cos_v,
	output logic signed [wpe_pkg::XyW-1:0]   sin_v
);

	logic signed [wpe_pkg::XyW-1:0] x_q, y_q, dx, dy;
	logic signed [wpe_pkg::ZW-1:0]  z_q, z_in, z_red;
	logic [wpe_pkg::StepW-1:0]      step_q;
	logic                           busy_q, done_q, flip_q, flip_in;

	// heading in units of 2^-13 rad, scaled to 2^-16 rad and folded into +-pi/2
	always_comb begin
		z_in = wpe_pkg::ZW'(heading) <<< 3;
		flip_in = 1'b1;
		if (z_in > wpe_pkg::HalfPiQ16) begin
			z_red = z_in - wpe_pkg::PiQ16;
		end else if (z_in < -wpe_pkg::HalfPiQ16) begin
			z_red = z_in + wpe_pkg::PiQ16;
		end else begin
			z_red = z_in;
			flip_in = 1'b0;
		end
	end

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == wpe_pkg::StepW'(wpe_pkg::Steps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= wpe_pkg::GainInvQ24;
			y_q    <= '0;
			z_q    <= z_red;
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (!z_q[wpe_pkg::ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - wpe_pkg::atan_q16(step_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + wpe_pkg::atan_q16(step_q);
			end
		end
	end

	assign done  = done_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

>>> rtl/core/wpe_rotate.sv
// Body frame rotation: four products through one registered multiplier,
// accumulated into x and y sums, then rounded and saturated. Depends on wpe_pkg.
`timescale 1ns / 1ps

module wpe_rotate (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [wpe_pkg::ErrW-1:0]  err_x,
	input  logic signed [wpe_pkg::ErrW-1:0]  err_y,
	input  logic signed [wpe_pkg::XyW-1:0]   cos_v,
	input  logic signed [wpe_pkg::XyW-1:0]   sin_v,
	output logic                             done,
	output logic signed [15:0]               body_x,
	output logic signed [15:0]               body_y
);

	logic                             busy_q, pv_s1, done_q;
	logic [1:0]                       cnt_q, psel_s1;
	logic signed [wpe_pkg::ErrW-1:0]  mul_a;
	logic signed [wpe_pkg::XyW-1:0]   mul_b;
	logic signed [wpe_pkg::ProdW-1:0] prod_s1;
	logic signed [wpe_pkg::AccW-1:0]  accx_q, accy_q;

	// order: ex*c, ey*s into x; ey*c, ex*s into y
	assign mul_a = (cnt_q inside {2'd1, 2'd2}) ? err_y : err_x;
	assign mul_b = cnt_q[0] ? sin_v : cos_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			pv_s1  <= busy_q;
			done_q <= pv_s1 && (psel_s1 == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_s1 <= mul_a * mul_b;
			psel_s1 <= cnt_q;
		end
		if (pv_s1) begin
			case (psel_s1)
				2'd0:    accx_q <= wpe_pkg::AccW'(prod_s1);
				2'd1:    accx_q <= accx_q + wpe_pkg::AccW'(prod_s1);
				2'd2:    accy_q <= wpe_pkg::AccW'(prod_s1);
				default: accy_q <= accy_q - wpe_pkg::AccW'(prod_s1);
			endcase
		end
	end

	assign done   = done_q;
	assign body_x = wpe_pkg::sat_round(accx_q);
	assign body_y = wpe_pkg::sat_round(accy_q);

endmodule

>>> rtl/core/waypoint_error_body_frame.sv
// Top level of the waypoint error body frame block: configuration registers,
// time gate, sequencer and output register. Depends on wpe_pkg, wpe_cordic, wpe_rotate.
`timescale 1ns / 1ps

// Usage:
// in_valid/in_ready/in_data take one vehicle sample per transfer. A sample is
// gated by time: it gives a result only when now_seconds exceeds the stored
// update time by more than 7; a passing sample with frame_end set stores its
// time. Gated-out samples and out-of-range indexes give no result and leave
// in_ready high.
// A passing sample runs 16 CORDIC steps on the shift-add unit, then four
// products on one registered multiplier, then waits in the sequencer until the
// output register is free and is loaded into it. in_ready is low while that
// work runs, so the block takes no new sample before the last one is through.
// out_valid/out_ready/out_data carry results. A stalled receiver holds the
// result in the output register; the next sample is still taken and computed,
// and then waits in the sequencer until the output register frees up.
// cfg_valid/cfg_ready/cfg_index/cfg_data write ref_x0..3 (index 0..3) and
// ref_y0..3 (index 4..7); cfg_ready is always high.
// arst_n resets waypoints to their defaults, the update time to zero and
// empties the output register.
module waypoint_error_body_frame (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wpe_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wpe_pkg::out_item_t            out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wpe_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [wpe_pkg::CfgW-1:0]      cfg_data
);

	localparam logic [1:0] StIdle   = 2'd0;
	localparam logic [1:0] StCordic = 2'd1;
	localparam logic [1:0] StRotate = 2'd2;
	localparam logic [1:0] StHold   = 2'd3;

	logic [1:0]                      state_q;
	logic signed [wpe_pkg::CfgW-1:0] ref_x_q [wpe_pkg::NumVehicles];
	logic signed [wpe_pkg::CfgW-1:0] ref_y_q [wpe_pkg::NumVehicles];
	logic [wpe_pkg::TimeW-1:0]       last_time_q;
	logic [wpe_pkg::TimeW:0]         diff;
	logic                            accept, pass, go;
	logic signed [wpe_pkg::ErrW-1:0] ex_q, ey_q;
	logic [wpe_pkg::IdxW-1:0]        idx_q;
	logic signed [15:0]              heading_q;
	logic                            last_q;
	logic                            out_valid_q;
	wpe_pkg::out_item_t              out_q;
	logic                            cordic_done, rot_done;
	logic signed [wpe_pkg::XyW-1:0]  cos_v, sin_v;
	logic signed [15:0]              body_x, body_y;
	logic                            out_free;

	assign in_ready  = (state_q == StIdle);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	// difference of unsigned times, kept exact in one extra bit
	assign diff = {1'b0, in_data.now_seconds} - {1'b0, last_time_q};
	assign pass = !diff[wpe_pkg::TimeW] && (diff[wpe_pkg::TimeW-1:0] > wpe_pkg::WaitSeconds);
	assign go   = pass &&
		({1'b0, in_data.vehicle_index} < (wpe_pkg::IdxW + 1)'(wpe_pkg::NumVehicles));
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wpe_pkg::NumVehicles; i++) begin
				ref_x_q[i] <= wpe_pkg::RefXReset[i];
				ref_y_q[i] <= wpe_pkg::RefYReset[i];
			end
		end else if (cfg_valid) begin
			if (cfg_index[wpe_pkg::CfgIdxW-1])
				ref_y_q[cfg_index[wpe_pkg::IdxW-1:0]] <= cfg_data;
			else
				ref_x_q[cfg_index[wpe_pkg::IdxW-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			last_time_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == StHold && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				StIdle: begin
					if (accept && pass && in_data.frame_end)
						last_time_q <= in_data.now_seconds;
					if (accept && go)
						state_q <= StCordic;
				end
				StCordic: begin
					if (cordic_done)
						state_q <= StRotate;
				end
				StRotate: begin
					if (rot_done)
						state_q <= StHold;
				end
				StHold: begin
					if (out_free)
						state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ex_q      <= wpe_pkg::ErrW'(ref_x_q[in_data.vehicle_index])
				- wpe_pkg::ErrW'(in_data.pos_x);
			ey_q      <= wpe_pkg::ErrW'(ref_y_q[in_data.vehicle_index])
				- wpe_pkg::ErrW'(in_data.pos_y);
			idx_q     <= in_data.vehicle_index;
			heading_q <= in_data.heading;
			last_q    <= in_data.frame_end;
		end
		if (state_q == StHold && out_free) begin
			out_q.out_index  <= idx_q;
			out_q.body_err_x <= body_x;
			out_q.body_err_y <= body_y;
			out_q.height_ref <= wpe_pkg::HeightQ12;
			out_q.yaw_err    <= (heading_q == 16'sh8000) ? 16'sh7fff : -heading_q;
			out_q.out_last   <= last_q;
		end
	end

	wpe_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept && go),
		.heading (in_data.heading),
		.done    (cordic_done),
		.cos_v   (cos_v),
		.sin_v   (sin_v)
	);

	wpe_rotate u_rotate (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_done),
		.err_x  (ex_q),
		.err_y  (ey_q),
		.cos_v  (cos_v),
		.sin_v  (sin_v),
		.done   (rot_done),
		.body_x (body_x),
		.body_y (body_y)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cordic_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		cordic_done |-> state_q == StCordic)
		else $error("CORDIC finished outside its phase");

	a_rot_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		rot_done |-> state_q == StRotate)
		else $error("rotation finished outside its phase");

	a_gated_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !go) |=> state_q == StIdle)
		else $error("gated sample started the engine");

	a_hold_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == StHold && !out_free) |=> (state_q == StHold && !in_ready))
		else $error("held result dropped while output busy");

endmodule

>>> dv/waypoint_error_body_frame_tb.sv
// Testbench for waypoint_error_body_frame: drives vehicle samples and waypoint writes,
// predicts the body-frame errors with its own CORDIC, and checks every result in order.
// Depends on wpe_pkg and the waypoint_error_body_frame RTL.
`timescale 1ns / 1ps

module waypoint_error_body_frame_tb;
	import wpe_pkg::*;

	localparam int     HoldOffCycles = 400;
	localparam int     DrainCycles   = 48;
	localparam int     StallLimit    = 5000;
	localparam int     RandomSamples = 1600;
	localparam int     ReloadEvery   = 400;
	localparam int     QuietTail     = 200;
	localparam longint GateSeconds   = 7;
	localparam longint HeightQ12Ref  = 1229;
	localparam longint CordicStartX  = 10188014;
	localparam longint HalfPiRad16   = 102944;
	localparam longint PiRad16       = 205887;
	localparam longint AtanRad16 [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	typedef enum logic [CfgIdxW-1:0] {
		REG_REF_X0, REG_REF_X1, REG_REF_X2, REG_REF_X3,
		REG_REF_Y0, REG_REF_Y1, REG_REF_Y2, REG_REF_Y3
	} waypoint_reg_e;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_item_t          out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0]    cfg_data = '0;

	// predictor state
	logic signed [15:0] wp_x [NumVehicles];
	logic signed [15:0] wp_y [NumVehicles];
	logic [31:0]        last_update_s;
	out_item_t          pending_results [$];
	out_item_t          want;

	int error_count = 0;
	int sample_count = 0;
	int result_count = 0;
	int cfg_count = 0;
	int idle_cycles = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit hold_rx = 1'b0;

	always #1 clk = ~clk;

	waypoint_error_body_frame i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// cos and sin of the heading, scaled by 2^24
	function automatic void yaw_cos_sin(input logic signed [15:0] hd, output longint c,
			output longint s);
		longint z, x, y, dx, dy;
		bit     flip;
		int     i;
		z = longint'(hd) * 8;
		x = CordicStartX;
		y = 0;
		flip = 1'b0;
		if (z > HalfPiRad16) begin
			z -= PiRad16;
			flip = 1'b1;
		end else if (z < -HalfPiRad16) begin
			z += PiRad16;
			flip = 1'b1;
		end
		for (i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= AtanRad16[i];
			end else begin
				x += dx;
				y -= dy;
				z += AtanRad16[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// returns 1 when the sample gives a result; moves the update time like the block does
	function automatic bit predict_body_error(input in_item_t smp, output out_item_t res);
		longint diff, ex, ey, c, s;
		res = '0;
		diff = longint'({32'h0, smp.now_seconds}) - longint'({32'h0, last_update_s});
		if (diff <= GateSeconds)
			return 1'b0;
		if (smp.frame_end)
			last_update_s = smp.now_seconds;
		if (smp.vehicle_index >= NumVehicles)
			return 1'b0;
		ex = longint'(wp_x[smp.vehicle_index]) - longint'(smp.pos_x);
		ey = longint'(wp_y[smp.vehicle_index]) - longint'(smp.pos_y);
		yaw_cos_sin(smp.heading, c, s);
		res.out_index  = smp.vehicle_index;
		res.body_err_x = clamp16((ex * c + ey * s + (longint'(1) << 23)) >>> 24);
		res.body_err_y = clamp16((ey * c - ex * s + (longint'(1) << 23)) >>> 24);
		res.height_ref = 15'(HeightQ12Ref);
		res.yaw_err    = clamp16(-longint'(smp.heading));
		res.out_last   = smp.frame_end;
		return 1'b1;
	endfunction

	function automatic in_item_t make_sample(input int idx, input int px, input int py,
			input int hd, input logic [31:0] t, input bit fe);
		in_item_t smp;
		smp.vehicle_index = IdxW'(idx);
		smp.pos_x         = 16'(px);
		smp.pos_y         = 16'(py);
		smp.heading       = 16'(hd);
		smp.now_seconds   = t;
		smp.frame_end     = fe;
		return smp;
	endfunction

	function automatic logic signed [15:0] pick_heading();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 51472)) - 25736);
	endfunction

	function automatic logic signed [15:0] pick_coord();
		case ($urandom_range(0, 7))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2, 3:    return 16'(int'($urandom_range(0, 8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void compare_field(input string name, input logic signed [31:0] e,
			input logic signed [31:0] a);
		if (a !== e) begin
			$error("%s expected %0d actual %0d", name, e, a);
			error_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: %p", out_data);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				result_count++;
				compare_field("out_index", want.out_index, out_data.out_index);
				compare_field("body_err_x", want.body_err_x, out_data.body_err_x);
				compare_field("body_err_y", want.body_err_y, out_data.body_err_y);
				compare_field("height_ref", want.height_ref, out_data.height_ref);
				compare_field("yaw_err", want.yaw_err, out_data.yaw_err);
				compare_field("out_last", want.out_last, out_data.out_last);
			end
		end
	end

	// watchdog: cycles with no transfer on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_rx) begin
				out_ready <= 1'b0;
				repeat (HoldOffCycles) @(posedge clk);
				hold_rx = 1'b0;
			end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	// valid stays high across back-to-back transfers; it only drops for a gap
	task automatic send_sample(input in_item_t smp);
		out_item_t res;
		if (!tx_quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= smp;
		do @(posedge clk); while (!in_ready);
		sample_count++;
		if (predict_body_error(smp, res))
			pending_results.push_back(res);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		// a sample that gives no result may still be in flight
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic load_waypoints(input logic signed [15:0] xs [NumVehicles],
			input logic signed [15:0] ys [NumVehicles]);
		int                 r;
		logic signed [15:0] v;
		for (r = REG_REF_X0; r <= REG_REF_Y3; r++) begin
			v = (r < REG_REF_Y0) ? xs[r] : ys[r - REG_REF_Y0];
			cfg_valid <= 1'b1;
			cfg_index <= waypoint_reg_e'(r);
			cfg_data  <= v;
			do @(posedge clk); while (!cfg_ready);
			if (r < REG_REF_Y0)
				wp_x[r] = v;
			else
				wp_y[r - REG_REF_Y0] = v;
			cfg_count++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic load_random_waypoints();
		logic signed [15:0] xs [NumVehicles];
		logic signed [15:0] ys [NumVehicles];
		int                 v;
		for (v = 0; v < NumVehicles; v++) begin
			xs[v] = pick_coord();
			ys[v] = pick_coord();
		end
		wait_idle();
		load_waypoints(xs, ys);
	endtask

	// one well-formed frame: shared passing time, frame end on the last sample
	task automatic send_frame(input int n);
		logic [31:0] t;
		int          k;
		t = last_update_s + 32'd8 + ($urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 60));
		for (k = 0; k < n; k++)
			send_sample(make_sample($urandom_range(0, NumVehicles - 1), pick_coord(),
				pick_coord(), pick_heading(), t, k == n - 1));
	endtask

	task automatic test_directed_cases();
		logic signed [15:0] xs [NumVehicles];
		logic signed [15:0] ys [NumVehicles];
		// frame end on a gated-out sample must not store its time
		send_sample(make_sample(0, 0, 0, 0, 5, 1));
		send_sample(make_sample(1, 0, 0, 0, 7, 0));
		send_sample(make_sample(0, 0, 0, 0, 8, 0));
		send_sample(make_sample(1, 32767, 32767, 25736, 8, 0));
		send_sample(make_sample(2, -32768, -32768, -25736, 8, 0));
		send_sample(make_sample(3, -32768, 32767, 32767, 8, 0));
		send_sample(make_sample(0, 32767, -32768, -32768, 8, 0));
		// right at and just past the quarter-turn fold
		send_sample(make_sample(1, 1234, -4321, 12868, 8, 0));
		send_sample(make_sample(2, -777, 999, 12869, 8, 0));
		send_sample(make_sample(3, 4096, 4096, -12868, 8, 0));
		send_sample(make_sample(0, -4096, 8192, -12869, 8, 1));
		send_sample(make_sample(1, 0, 0, 6434, 15, 1));
		send_sample(make_sample(2, 0, 0, 0, 3, 1));
		send_sample(make_sample(3, 100, -100, -6434, 16, 1));
		wait_idle();
		xs = '{4{16'sh7fff}};
		ys = '{4{16'sh8000}};
		load_waypoints(xs, ys);
		send_sample(make_sample(0, -32768, 32767, 0, 100, 0));
		send_sample(make_sample(1, -32768, 32767, 6434, 100, 0));
		send_sample(make_sample(2, -32768, 32767, -19302, 100, 1));
		wait_idle();
		xs = '{4{16'sh8000}};
		ys = '{4{16'sh7fff}};
		load_waypoints(xs, ys);
		send_sample(make_sample(3, 32767, -32768, 0, 200, 0));
		send_sample(make_sample(0, 32767, -32768, 25736, 200, 1));
	endtask

	task automatic test_waypoint_settings();
		logic signed [15:0] xs [NumVehicles];
		logic signed [15:0] ys [NumVehicles];
		int                 s, f;
		wait_idle();
		xs = '{16'sd1638, 16'sd1638, -16'sd1638, -16'sd1638};
		ys = '{16'sd1638, -16'sd1638, -16'sd1638, 16'sd1638};
		load_waypoints(xs, ys);
		for (s = 0; s < 4; s++) begin
			for (f = 0; f < 8; f++)
				send_frame($urandom_range(1, NumVehicles));
			load_random_waypoints();
		end
	endtask

	// receiver holds off while samples keep coming, so the block must stall its input
	task automatic test_output_backpressure();
		int k;
		logic [31:0] t;
		wait_idle();
		hold_rx = 1'b1;
		tx_quiet = 1'b1;
		t = last_update_s + 32'd8;
		for (k = 0; k < 8; k++)
			send_sample(make_sample(k % NumVehicles, pick_coord(), pick_coord(),
				pick_heading(), t, k == 7));
		tx_quiet = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int          start, sent, next_reload, k, n;
		logic [31:0] t;
		start = sample_count;
		next_reload = ReloadEvery;
		sent = 0;
		while (sent < RandomSamples) begin
			if (sent >= next_reload) begin
				load_random_waypoints();
				next_reload += ReloadEvery;
			end
			if (sent >= RandomSamples - QuietTail) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5, 6:
					send_frame($urandom_range(1, NumVehicles));
				7:  // any time at all, no frame end, so the update time stays put
					send_sample(make_sample($urandom_range(0, NumVehicles - 1), pick_coord(),
						pick_coord(), pick_heading(), $urandom, 0));
				8:  // too early, sometimes with a frame end
					send_sample(make_sample($urandom_range(0, NumVehicles - 1), pick_coord(),
						pick_coord(), pick_heading(), last_update_s + $urandom_range(0, 7),
						$urandom_range(0, 1)));
				default: begin
					if ($urandom_range(0, 1) == 0 && last_update_s != 0) begin
						// time runs backwards
						t = last_update_s - $urandom_range(1, 1000);
						send_sample(make_sample($urandom_range(0, NumVehicles - 1),
							pick_coord(), pick_coord(), pick_heading(), t, 1));
					end else begin
						// broken frame: passing samples that never close the frame
						n = $urandom_range(1, 3);
						t = last_update_s + 32'd8 + $urandom_range(0, 20);
						for (k = 0; k < n; k++)
							send_sample(make_sample($urandom_range(0, NumVehicles - 1),
								pick_coord(), pick_coord(), pick_heading(), t, 0));
					end
				end
			endcase
			sent = sample_count - start;
		end
	endtask

	// once the update time sits at the top of the range nothing can pass again
	task automatic test_time_ceiling();
		send_sample(make_sample(2, pick_coord(), pick_coord(), pick_heading(),
			32'hffff_fff7, 0));
		send_sample(make_sample(3, pick_coord(), pick_coord(), pick_heading(),
			32'hffff_ffff, 1));
		send_sample(make_sample(0, pick_coord(), pick_coord(), pick_heading(),
			32'hffff_ffff, 0));
		send_sample(make_sample(1, pick_coord(), pick_coord(), pick_heading(), 32'h0, 1));
	endtask

	initial begin
		wp_x = '{16'sd1638, 16'sd1638, -16'sd1638, -16'sd1638};
		wp_y = '{16'sd1638, -16'sd1638, -16'sd1638, 16'sd1638};
		last_update_s = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_waypoint_settings();
		test_output_backpressure();
		test_random_traffic();
		test_time_ceiling();
		wait_idle();
		$display("summary: %0d samples, %0d results checked, %0d register writes",
			sample_count, result_count, cfg_count);
		$display("summary: time gate edges, heading folds and saturation, waypoint extremes,");
		$display("summary: random and idle-free traffic, one long output hold-off");
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
